// ===== hdl/blpd_pkg.sv =====
// Shared types, codes and reset values of the button gesture detector.
package blpd_pkg;

    localparam int STAMP_W = 32;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int TAPS_W  = 4;
    localparam int MS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONV    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONSOLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADJACENT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd3;

    localparam logic [TAPS_W-1:0] RST_TAP_TARGET = 4'd10;
    localparam logic [MS_W-1:0]   RST_TAP_WINDOW = 16'd5000;
    localparam logic [MS_W-1:0]   RST_ADJACENT   = 16'd500;
    localparam logic [MS_W-1:0]   RST_LONG_PRESS = 16'd500;

    typedef struct packed {
        logic [TAPS_W-1:0] tap_target;
        logic [MS_W-1:0]   tap_window_ms;
        logic [MS_W-1:0]   adjacent_tap_ms;
        logic [MS_W-1:0]   long_press_ms;
    } blpd_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               held;
        logic [STAMP_W-1:0] press_start;
        logic [STAMP_W-1:0] first_tap;
        logic [STAMP_W-1:0] last_release;
        logic [TAPS_W-1:0]  taps;
    } blpd_state_t;

endpackage

// ===== hdl/blpd_event_if.sv =====
// Event input channel: valid/ready with event kind and time stamp.
interface blpd_event_if;
    logic                        valid;
    logic                        ready;
    logic [blpd_pkg::KIND_W-1:0]  kind;
    logic [blpd_pkg::STAMP_W-1:0] stamp_ms;

    modport source (output valid, output kind, output stamp_ms, input ready);
    modport sink   (input valid, input kind, input stamp_ms, output ready);
endinterface

// ===== hdl/blpd_result_if.sv =====
// Result output channel: valid/ready with mode, tap count and held flag.
interface blpd_result_if;
    logic                        valid;
    logic                        ready;
    logic [blpd_pkg::MODE_W-1:0] mode_now;
    logic [blpd_pkg::TAPS_W-1:0] taps_now;
    logic                        held_now;

    modport source (output valid, output mode_now, output taps_now, output held_now,
                    input ready);
    modport sink   (input valid, input mode_now, input taps_now, input held_now,
                    output ready);
endinterface

// ===== hdl/blpd_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface blpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [blpd_pkg::CFG_IDX_W-1:0]  index;
    logic [blpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/blpd_step.sv =====
// Next-state logic of the gesture detector for one button event.
module blpd_step (
    input  logic [blpd_pkg::KIND_W-1:0]  kind,
    input  logic [blpd_pkg::STAMP_W-1:0] stamp_ms,
    input  blpd_pkg::blpd_cfg_t          cfg,
    input  blpd_pkg::blpd_state_t        cur,
    output blpd_pkg::blpd_state_t        nxt
);
    import blpd_pkg::*;

    logic [STAMP_W:0]   since_press;
    logic [STAMP_W:0]   since_release;
    logic [STAMP_W:0]   since_first;
    logic               active;
    logic               is_long;
    logic               restart;
    logic [TAPS_W:0]    count;

    always_comb
    begin
        since_press   = {1'b0, stamp_ms} - {1'b0, cur.press_start};
        since_release = {1'b0, stamp_ms} - {1'b0, cur.last_release};
        since_first   = {1'b0, stamp_ms} - {1'b0, cur.first_tap};
        active        = cur.held && (cur.mode != MODE_CONSOLE);
        // a borrow means the stamp lies before the reference time
        is_long = since_press[STAMP_W] ||
                  (since_press[STAMP_W-1:0] >= {{(STAMP_W-MS_W){1'b0}}, cfg.long_press_ms});
        restart = (cur.taps == '0) ||
                  since_release[STAMP_W] ||
                  (since_release[STAMP_W-1:0] >
                   {{(STAMP_W-MS_W){1'b0}}, cfg.adjacent_tap_ms}) ||
                  since_first[STAMP_W] ||
                  (since_first[STAMP_W-1:0] >
                   {{(STAMP_W-MS_W){1'b0}}, cfg.tap_window_ms});
        count = restart ? {{TAPS_W{1'b0}}, 1'b1} : ({1'b0, cur.taps} + 1'b1);

        nxt = cur;
        case (kind)
            KIND_PRESS:
            begin
                if (!cur.held && (cur.mode != MODE_CONSOLE))
                begin
                    nxt.held        = 1'b1;
                    nxt.press_start = stamp_ms;
                end
            end
            KIND_RELEASE:
            begin
                nxt.held = 1'b0;
                if (active)
                begin
                    if (is_long)
                    begin
                        nxt.first_tap    = '0;
                        nxt.last_release = '0;
                        nxt.taps         = '0;
                        nxt.mode         = MODE_CONV;
                    end
                    else if (count >= {1'b0, cfg.tap_target})
                    begin
                        nxt.first_tap    = '0;
                        nxt.last_release = '0;
                        nxt.taps         = '0;
                        nxt.mode         = MODE_CONSOLE;
                    end
                    else
                    begin
                        nxt.first_tap    = restart ? stamp_ms : cur.first_tap;
                        nxt.last_release = stamp_ms;
                        nxt.taps         = count[TAPS_W-1:0];
                        nxt.mode         = MODE_IDLE;
                    end
                end
            end
            KIND_TICK:
            begin
                if (active && !since_press[STAMP_W] && is_long)
                begin
                    nxt.first_tap    = '0;
                    nxt.last_release = '0;
                    nxt.taps         = '0;
                    nxt.mode         = MODE_CONV;
                end
            end
            KIND_CLOSE:
            begin
                if (cur.mode == MODE_CONSOLE)
                begin
                    nxt.first_tap    = '0;
                    nxt.last_release = '0;
                    nxt.taps         = '0;
                    nxt.mode         = MODE_IDLE;
                    nxt.held         = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== hdl/button_long_press_multi_tap_detector_unit.sv =====
// Top level of the button long-press and multi-tap gesture detector.
// Each accepted event transfer gives exactly one result transfer carrying the
// mode, the quick-tap count and the held flag after that event. Events are
// taken one per clock while no result waits unaccepted; each event passes
// through the event register, then the result register, and the gesture state is
// updated in the cycle in which an event moves from the event register to the
// result register. Configuration writes are taken at any time and apply to later
// events; they are meant to be issued only while no event is in flight.
module button_long_press_multi_tap_detector_unit (
    input  logic          clk,
    input  logic          rst_n,
    blpd_event_if.sink    evt,
    blpd_result_if.source res,
    blpd_cfg_if.sink      cfg
);
    import blpd_pkg::*;

    logic                 evt_valid_reg;
    logic [KIND_W-1:0]    evt_kind_reg;
    logic [STAMP_W-1:0]   evt_stamp_reg;
    logic                 res_valid_reg;
    logic [MODE_W-1:0]    res_mode_reg;
    logic [TAPS_W-1:0]    res_taps_reg;
    logic                 res_held_reg;
    blpd_state_t          state_reg;
    blpd_state_t          state_next;
    blpd_cfg_t            cfg_reg;
    logic                 advance;

    assign advance   = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign res.valid    = res_valid_reg;
    assign res.mode_now = res_mode_reg;
    assign res.taps_now = res_taps_reg;
    assign res.held_now = res_held_reg;

    blpd_step u_step (
        .kind     (evt_kind_reg),
        .stamp_ms (evt_stamp_reg),
        .cfg      (cfg_reg),
        .cur      (state_reg),
        .nxt      (state_next)
    );

    // event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            evt_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            evt_kind_reg  <= evt.kind;
            evt_stamp_reg <= evt.stamp_ms;
        end
    end

    // gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_mode_reg <= state_next.mode;
            res_taps_reg <= state_next.taps;
            res_held_reg <= state_next.held;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_target      <= RST_TAP_TARGET;
            cfg_reg.tap_window_ms   <= RST_TAP_WINDOW;
            cfg_reg.adjacent_tap_ms <= RST_ADJACENT;
            cfg_reg.long_press_ms   <= RST_LONG_PRESS;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_TAP_TARGET: cfg_reg.tap_target      <= cfg.data[TAPS_W-1:0];
                REG_TAP_WINDOW: cfg_reg.tap_window_ms   <= cfg.data[MS_W-1:0];
                REG_ADJACENT:   cfg_reg.adjacent_tap_ms <= cfg.data[MS_W-1:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms   <= cfg.data[MS_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !evt.ready |-> (res_valid_reg && !res.ready))
        else $error("event side stalled while result side could move");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("event moved on without a result");

    a_console_no_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_CONSOLE) |-> (state_reg.taps == '0))
        else $error("tap count kept in console mode");

    a_conv_no_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_CONV) |-> (state_reg.taps == '0))
        else $error("tap count kept in conversation mode");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_mode_reg == state_reg.mode && res_held_reg == state_reg.held))
        else $error("result differs from updated state");

endmodule
